@@ src/kvst_pkg.sv @@
// Shared types, codes and defaults of the keyed value statistics table.
`default_nettype none
package kvst_pkg;

    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int VALUE_SLOTS_DEF   = 2;
    localparam int KEY_BITS_DEF      = 64;

    localparam int VAL_W = 64;
    localparam int CNT_W = 32;
    localparam int KEY_W = 64;
    localparam int CFG_W = 32;
    localparam int CFG_AW = 3;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_CREATED   = 2'd1;
    localparam t_status ST_NOT_FOUND = 2'd2;
    localparam t_status ST_FULL      = 2'd3;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    localparam logic REG_VALUES_IN_USE = 1'b0;
    localparam logic REG_SIGNED_MASK   = 1'b1;

    typedef enum logic {
        OP_ADD,
        OP_LT
    } t_alu_op;

    typedef struct packed {
        logic             kind;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value_a;
        logic [VAL_W-1:0] value_b;
        logic             value_index;
    } t_req;

    typedef struct packed {
        t_status          status;
        logic [VAL_W-1:0] last_value;
        logic [CNT_W-1:0] sample_count;
        logic [VAL_W-1:0] min_value;
        logic [VAL_W-1:0] max_value;
        logic [VAL_W-1:0] sum_value;
    } t_rsp;

    typedef struct packed {
        logic [VAL_W-1:0] last;
        logic [CNT_W-1:0] count;
        logic [VAL_W-1:0] min;
        logic [VAL_W-1:0] max;
        logic [VAL_W-1:0] sum;
    } t_stat;

endpackage
`default_nettype wire

@@ src/keyed_value_statistics_table.sv @@
// Top level of the keyed value statistics table with its search and update sequencer.
//
// A request is taken when start is high and busy is low; busy then stays high until the
// result strobe o_done, which lasts one cycle and cannot be held off. The strobe comes in
// the cycle after the last sequencer step, when busy is already low. Each request first
// searches the key store one entry per cycle over the entries in use. A query that hits a
// slot in use then reads it in S_QRD and S_QLOAD. An insert to an existing key goes through,
// for each slot in use, a read, a load, the max and min compares, the sum through the one shared
// 64-bit adder and comparator, and a write back, and a new key writes each value slot in
// turn. Entries are claimed in order and never freed, so a fill count marks the valid
// entries and no clearing pass runs after reset.
`default_nettype none
module keyed_value_statistics_table #(
    parameter int TABLE_ENTRIES = kvst_pkg::TABLE_ENTRIES_DEF,
    parameter int VALUE_SLOTS   = kvst_pkg::VALUE_SLOTS_DEF,
    parameter int KEY_BITS      = kvst_pkg::KEY_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire kvst_pkg::t_req                i_req,
    output logic                               o_done,
    output kvst_pkg::t_rsp                     o_rsp,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [kvst_pkg::CFG_AW-1:0]   paddr,
    input  wire logic [kvst_pkg::CFG_W-1:0]    pwdata,
    output logic      [kvst_pkg::CFG_W-1:0]    prdata,
    output logic                               pready
);

    import kvst_pkg::*;

    localparam int IDX_W      = $clog2(TABLE_ENTRIES);
    localparam int FILL_W     = IDX_W + 1;
    localparam int SLOT_DEPTH = TABLE_ENTRIES * VALUE_SLOTS;
    localparam int SLOT_AW    = $clog2(SLOT_DEPTH);
    localparam int STAT_W     = $bits(t_stat);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_SCAN  = 11'b00000000010,
        S_CWR   = 11'b00000000100,
        S_SRD   = 11'b00000001000,
        S_LOAD  = 11'b00000010000,
        S_MAX   = 11'b00000100000,
        S_MIN   = 11'b00001000000,
        S_ADD   = 11'b00010000000,
        S_WR    = 11'b00100000000,
        S_QRD   = 11'b01000000000,
        S_QLOAD = 11'b10000000000
    } t_state;

    t_state            r_state, n_state;
    t_req              r_req, n_req;
    logic [FILL_W-1:0] r_idx, n_idx;
    logic              r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]  r_cmp_idx, n_cmp_idx;
    logic [IDX_W-1:0]  r_entry, n_entry;
    logic              r_slot, n_slot;
    t_stat             r_stat, n_stat;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [1:0]        r_viu;
    logic [1:0]        r_mask;
    logic              r_done, n_done;
    t_rsp              r_rsp, n_rsp;

    logic [1:0]          active;
    logic [KEY_BITS-1:0] key_in;
    logic [KEY_BITS-1:0] key_rd;
    logic [VAL_W-1:0]    cur_val;
    logic                cur_sgn;
    logic [SLOT_AW-1:0]  slot_addr;
    logic                key_we;
    logic                slot_we;
    t_stat               slot_wdata;
    t_stat               slot_rd;
    logic [STAT_W-1:0]   slot_rd_bits;
    t_stat               create_stat;
    logic                hit;
    logic                last_upd;
    logic                last_create;

    t_alu_op           alu_op;
    logic [VAL_W-1:0]  alu_a, alu_b, a_x, b_x, b_op, flip;
    logic [VAL_W:0]    alu_full;
    logic              alu_sub;
    logic              alu_lt;
    logic [VAL_W-1:0]  alu_sum;

    assign active    = (r_viu > 2'(VALUE_SLOTS)) ? 2'(VALUE_SLOTS) : r_viu;
    assign key_in    = r_req.key[KEY_BITS-1:0];
    assign cur_val   = r_slot ? r_req.value_b : r_req.value_a;
    assign cur_sgn   = r_mask[r_slot];
    assign slot_addr = SLOT_AW'(SLOT_AW'(r_entry) * SLOT_AW'(VALUE_SLOTS)) + SLOT_AW'(r_slot);
    assign slot_rd   = t_stat'(slot_rd_bits);
    assign hit       = r_cmp_vld && (key_rd == key_in);
    assign last_upd    = (2'(r_slot) + 2'd1) == active;
    assign last_create = (2'(r_slot) + 2'd1) == 2'(VALUE_SLOTS);

    always_comb begin
        create_stat = '0;
        if (2'(r_slot) < active) begin
            create_stat.last  = cur_val;
            create_stat.count = CNT_W'(1);
            create_stat.min   = cur_val;
            create_stat.max   = cur_val;
            create_stat.sum   = cur_val;
        end
    end

    always_comb begin
        case (r_state)
            S_MAX: begin
                alu_op = OP_LT;
                alu_a  = r_stat.max;
                alu_b  = cur_val;
            end
            S_MIN: begin
                alu_op = OP_LT;
                alu_a  = cur_val;
                alu_b  = r_stat.min;
            end
            default: begin
                alu_op = OP_ADD;
                alu_a  = r_stat.sum;
                alu_b  = cur_val;
            end
        endcase
    end

    assign alu_sub  = (alu_op == OP_LT);
    assign flip     = {alu_sub & cur_sgn, {(VAL_W-1){1'b0}}};
    assign a_x      = alu_a ^ flip;
    assign b_x      = alu_b ^ flip;
    assign b_op     = alu_sub ? ~b_x : b_x;
    assign alu_full = {1'b0, a_x} + {1'b0, b_op} + {{VAL_W{1'b0}}, alu_sub};
    assign alu_lt   = ~alu_full[VAL_W];
    assign alu_sum  = alu_full[VAL_W-1:0];

    kvst_ram #(
        .WIDTH(KEY_BITS),
        .DEPTH(TABLE_ENTRIES)
    ) u_key_ram (
        .i_clk  (i_clk),
        .i_we   (key_we),
        .i_waddr(r_fill[IDX_W-1:0]),
        .i_wdata(key_in),
        .i_raddr(r_idx[IDX_W-1:0]),
        .o_rdata(key_rd)
    );

    kvst_ram #(
        .WIDTH(STAT_W),
        .DEPTH(SLOT_DEPTH)
    ) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (slot_we),
        .i_waddr(slot_addr),
        .i_wdata(slot_wdata),
        .i_raddr(slot_addr),
        .o_rdata(slot_rd_bits)
    );

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_idx      = r_idx;
        n_cmp_vld  = r_cmp_vld;
        n_cmp_idx  = r_cmp_idx;
        n_entry    = r_entry;
        n_slot     = r_slot;
        n_stat     = r_stat;
        n_fill     = r_fill;
        n_done     = 1'b0;
        n_rsp      = r_rsp;
        key_we     = 1'b0;
        slot_we    = 1'b0;
        slot_wdata = r_stat;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req     = i_req;
                    n_idx     = '0;
                    n_cmp_vld = 1'b0;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                n_cmp_vld = r_idx < r_fill;
                n_cmp_idx = r_idx[IDX_W-1:0];
                if (r_idx < r_fill) begin
                    n_idx = r_idx + FILL_W'(1);
                end
                if (hit) begin
                    n_entry = r_cmp_idx;
                    n_slot  = 1'b0;
                    if (r_req.kind == KIND_INSERT) begin
                        if (active == 2'd0) begin
                            n_done       = 1'b1;
                            n_rsp        = '0;
                            n_rsp.status = ST_OK;
                            n_state      = S_IDLE;
                        end else begin
                            n_state = S_SRD;
                        end
                    end else if (2'(r_req.value_index) < active) begin
                        n_slot  = r_req.value_index;
                        n_state = S_QRD;
                    end else begin
                        n_done       = 1'b1;
                        n_rsp        = '0;
                        n_rsp.status = ST_OK;
                        n_state      = S_IDLE;
                    end
                end else if (!r_cmp_vld && (r_idx == r_fill)) begin
                    if (r_req.kind == KIND_QUERY) begin
                        n_done       = 1'b1;
                        n_rsp        = '0;
                        n_rsp.status = ST_NOT_FOUND;
                        n_state      = S_IDLE;
                    end else if (r_fill == FILL_W'(TABLE_ENTRIES)) begin
                        n_done       = 1'b1;
                        n_rsp        = '0;
                        n_rsp.status = ST_FULL;
                        n_state      = S_IDLE;
                    end else begin
                        key_we  = 1'b1;
                        n_entry = r_fill[IDX_W-1:0];
                        n_fill  = r_fill + FILL_W'(1);
                        n_slot  = 1'b0;
                        n_state = S_CWR;
                    end
                end
            end
            S_CWR: begin
                slot_we    = 1'b1;
                slot_wdata = create_stat;
                if (last_create) begin
                    n_done       = 1'b1;
                    n_rsp        = '0;
                    n_rsp.status = ST_CREATED;
                    n_state      = S_IDLE;
                end else begin
                    n_slot = 1'b1;
                end
            end
            S_SRD: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_stat  = slot_rd;
                n_state = S_MAX;
            end
            S_MAX: begin
                if ((r_stat.count == '0) || alu_lt) begin
                    n_stat.max = cur_val;
                end
                n_state = S_MIN;
            end
            S_MIN: begin
                if ((r_stat.count == '0) || alu_lt) begin
                    n_stat.min = cur_val;
                end
                n_state = S_ADD;
            end
            S_ADD: begin
                n_stat.sum  = (r_stat.count == '0) ? cur_val : alu_sum;
                n_stat.last = cur_val;
                if (r_stat.count != '1) begin
                    n_stat.count = r_stat.count + CNT_W'(1);
                end
                n_state = S_WR;
            end
            S_WR: begin
                slot_we    = 1'b1;
                slot_wdata = r_stat;
                if (last_upd) begin
                    n_done       = 1'b1;
                    n_rsp        = '0;
                    n_rsp.status = ST_OK;
                    n_state      = S_IDLE;
                end else begin
                    n_slot  = 1'b1;
                    n_state = S_SRD;
                end
            end
            S_QRD: begin
                n_state = S_QLOAD;
            end
            S_QLOAD: begin
                n_done             = 1'b1;
                n_rsp.status       = ST_OK;
                n_rsp.last_value   = slot_rd.last;
                n_rsp.sample_count = slot_rd.count;
                n_rsp.min_value    = slot_rd.min;
                n_rsp.max_value    = slot_rd.max;
                n_rsp.sum_value    = slot_rd.sum;
                n_state            = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_done  <= 1'b0;
            r_viu   <= 2'd2;
            r_mask  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_done  <= n_done;
            if (psel && penable && pwrite) begin
                if (paddr[2] == REG_VALUES_IN_USE) begin
                    r_viu <= pwdata[1:0];
                end else begin
                    r_mask <= pwdata[1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_idx     <= n_idx;
        r_cmp_vld <= n_cmp_vld;
        r_cmp_idx <= n_cmp_idx;
        r_entry   <= n_entry;
        r_slot    <= n_slot;
        r_stat    <= n_stat;
        r_rsp     <= n_rsp;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SIGNED_MASK) ? {{(CFG_W-2){1'b0}}, r_mask}
                                                  : {{(CFG_W-2){1'b0}}, r_viu};

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_fell_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("request finished without a result");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(TABLE_ENTRIES))
        else $error("fill count beyond table size");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_rsp.status == ST_FULL) |-> r_fill == FILL_W'(TABLE_ENTRIES))
        else $error("table full reported with free entries");

endmodule
`default_nettype wire

@@ src/kvst_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module kvst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire
